// File: rtl/core/vgg_pkg.sv
// Shared constants and types for the vertical grain grouper.
// Used by every module under rtl/core; depends on nothing else.
package vgg_pkg;

    // Default cluster limit of one grain.
    localparam int MAX_CLUSTERS_DEF = 1023;

    // Width of the serial divider datapath; holds area sum times z length.
    localparam int DIV_W = 64;

    // Width of the z length magnitude fed to the serial multiplier.
    localparam int ZMAG_W = 32;

    // Register indexes on the configuration port.
    localparam logic REG_BIN_Z = 1'b0;
    localparam logic REG_MIN_CLUSTERS = 1'b1;

    // Reset values of the registers.
    localparam logic [15:0] BIN_Z_RST = 16'd256;
    localparam logic [9:0] MIN_CLUSTERS_RST = 10'd1;

    // Marker for a volume that cannot be computed.
    localparam logic [63:0] VOLUME_INVALID = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VOLUME_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

    // Grain queue status seen by the input handshake and the back end.
    typedef struct packed {
        logic room2;
        logic nonempty;
    } q_status_t;

endpackage

// File: rtl/core/vertical_grain_grouper_core.sv
// Vertical grain grouper: cluster input channel, grain output channel and
// an APB register port. Instantiates vgg_front, vgg_queue and vgg_back.
//
// Clusters arrive on x_pos..column_end with in_valid/in_stall, sorted by
// column and then z. The front end takes one request per cycle as long as
// the grain queue has room for two grains, since one cluster can close two.
// Each closed grain that reaches min_clusters is worked out by the back end:
// one 32 step shift-add multiply for the volume, then four 64 step serial
// divisions (three means and the volume); the grain then goes to its
// output register. Grain results leave on out_valid/out_stall; the output
// register holds while out_stall is high and the back end waits, after
// which the queue and then in_stall fill up. The back end takes a new grain
// only once the last one is in the output register; the sustained grain
// rate is set by the serial divider.
// Registers: bin_z at address 0 (reset 256), min_clusters at 4 (reset 1);
// write them only while the block is idle. Reset clears the open grain,
// empties the queue and drops out_valid.
module vertical_grain_grouper_core #(
    parameter int MAX_CLUSTERS = vgg_pkg::MAX_CLUSTERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  x_pos,
    input  logic signed [31:0]  y_pos,
    input  logic signed [31:0]  z_pos,
    input  logic [15:0]         area,
    input  logic [9:0]          frame,
    input  logic                column_end,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          cluster_count,
    output logic signed [31:0]  mean_x,
    output logic signed [31:0]  mean_y,
    output logic signed [31:0]  mean_z,
    output logic signed [63:0]  volume,
    output logic [15:0]         area_least,
    output logic [15:0]         area_greatest,
    output logic signed [31:0]  z_at_frame_high,
    output logic signed [31:0]  z_at_frame_low,
    output logic [9:0]          frame_low,
    output logic [9:0]          frame_high,
    output logic                last_of_run
);

    localparam int CW = $clog2(MAX_CLUSTERS + 1);
    localparam int SW = 32 + CW;
    localparam int AW = 16 + CW;
    localparam int REC_W = 1 + CW + 3 * SW + AW + 32 + 20 + 64;

    logic [15:0] bin_z_reg;
    logic [9:0] min_clusters_reg;

    // Register port.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_z_reg <= vgg_pkg::BIN_Z_RST;
            min_clusters_reg <= vgg_pkg::MIN_CLUSTERS_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == vgg_pkg::REG_BIN_Z)
                bin_z_reg <= pwdata[15:0];
            else
                min_clusters_reg <= pwdata[9:0];
        end
    end

    assign prdata = (paddr[2] == vgg_pkg::REG_MIN_CLUSTERS) ? {22'b0, min_clusters_reg}
                                                           : {16'b0, bin_z_reg};

    vgg_pkg::q_status_t q_status;
    logic accept, push0, push1, pop;
    logic [REC_W-1:0] rec0, rec1, head;

    assign in_stall = !q_status.room2;
    assign accept = in_valid && !in_stall;

    vgg_front #(
        .MAX_CLUSTERS(MAX_CLUSTERS), .CW(CW), .SW(SW), .AW(AW), .REC_W(REC_W)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept),
        .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos), .area(area), .frame(frame),
        .column_end(column_end), .bin_z(bin_z_reg), .min_clusters(min_clusters_reg),
        .push0(push0), .push1(push1), .rec0(rec0), .rec1(rec1)
    );

    vgg_queue #(.REC_W(REC_W)) u_queue (
        .clk(clk), .rst_n(rst_n), .push0(push0), .push1(push1),
        .rec0(rec0), .rec1(rec1), .pop(pop), .head(head), .status(q_status)
    );

    vgg_back #(
        .MAX_CLUSTERS(MAX_CLUSTERS), .CW(CW), .SW(SW), .AW(AW), .REC_W(REC_W)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .status(q_status), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .cluster_count(cluster_count), .mean_x(mean_x), .mean_y(mean_y),
        .mean_z(mean_z), .volume(volume), .area_least(area_least),
        .area_greatest(area_greatest), .z_at_frame_high(z_at_frame_high),
        .z_at_frame_low(z_at_frame_low), .frame_low(frame_low),
        .frame_high(frame_high), .last_of_run(last_of_run)
    );

endmodule

// File: rtl/core/vgg_front.sv
// Front end: accepts clusters, keeps the open grain's statistics and
// pushes closed grains into the grain queue. Depends on vgg_pkg.
module vgg_front #(
    parameter int MAX_CLUSTERS = vgg_pkg::MAX_CLUSTERS_DEF,
    parameter int CW = $clog2(MAX_CLUSTERS + 1),
    parameter int SW = 32 + CW,
    parameter int AW = 16 + CW,
    parameter int REC_W = 1 + CW + 3 * SW + AW + 32 + 20 + 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic signed [31:0]      x_pos,
    input  logic signed [31:0]      y_pos,
    input  logic signed [31:0]      z_pos,
    input  logic [15:0]             area,
    input  logic [9:0]              frame,
    input  logic                    column_end,
    input  logic [15:0]             bin_z,
    input  logic [9:0]              min_clusters,
    output logic                    push0,
    output logic                    push1,
    output logic [REC_W-1:0]        rec0,
    output logic [REC_W-1:0]        rec1
);

    localparam logic [CW-1:0] CMAX = CW'(MAX_CLUSTERS);

    logic [CW-1:0]        cnt_reg;
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic [AW-1:0]        at_reg;
    logic [15:0]          alo_reg, ahi_reg;
    logic [9:0]           flo_reg, fhi_reg;
    logic signed [31:0]   zlo_reg, zhi_reg, prevz_reg;

    logic [CW-1:0]        b_cnt, cnt_next;
    logic signed [SW-1:0] b_sx, b_sy, b_sz, sx_next, sy_next, sz_next;
    logic [AW-1:0]        b_at, at_next;
    logic [15:0]          b_alo, b_ahi, alo_next, ahi_next;
    logic [9:0]           flo_next, fhi_next;
    logic signed [31:0]   zlo_next, zhi_next;
    logic signed [32:0]   z_diff;
    logic                 gap, emit1, emit2;

    // Gap test against the previous cluster.
    assign z_diff = $signed({z_pos[31], z_pos}) - $signed({prevz_reg[31], prevz_reg});
    assign gap = (cnt_reg != '0) && (z_diff > $signed({16'b0, bin_z, 1'b0}));
    assign emit1 = gap && ({{(17 - CW){1'b0}}, cnt_reg} >= {7'b0, min_clusters});

    // The cluster joins either the current grain or a fresh one, unless the grain already holds MAX_CLUSTERS clusters.
    always_comb
    begin
        b_cnt = gap ? '0 : cnt_reg;
        b_sx = gap ? '0 : sx_reg;
        b_sy = gap ? '0 : sy_reg;
        b_sz = gap ? '0 : sz_reg;
        b_at = gap ? '0 : at_reg;
        b_alo = gap ? 16'hFFFF : alo_reg;
        b_ahi = gap ? 16'h0000 : ahi_reg;
        cnt_next = b_cnt;
        sx_next = b_sx;
        sy_next = b_sy;
        sz_next = b_sz;
        at_next = b_at;
        alo_next = b_alo;
        ahi_next = b_ahi;
        flo_next = flo_reg;
        fhi_next = fhi_reg;
        zlo_next = zlo_reg;
        zhi_next = zhi_reg;
        if (b_cnt < CMAX)
        begin
            if (b_cnt == '0)
            begin
                flo_next = frame;
                fhi_next = frame;
                zlo_next = z_pos;
                zhi_next = z_pos;
            end
            else
            begin
                if (frame < flo_reg)
                begin
                    flo_next = frame;
                    zlo_next = z_pos;
                end
                if (frame > fhi_reg)
                begin
                    fhi_next = frame;
                    zhi_next = z_pos;
                end
            end
            if (area < b_alo)
                alo_next = area;
            if (area > b_ahi)
                ahi_next = area;
            sx_next = b_sx + SW'(x_pos);
            sy_next = b_sy + SW'(y_pos);
            sz_next = b_sz + SW'(z_pos);
            at_next = b_at + AW'(area);
            cnt_next = b_cnt + 1'b1;
        end
    end

    assign emit2 = column_end && (cnt_next != '0)
        && ({{(17 - CW){1'b0}}, cnt_next} >= {7'b0, min_clusters});

    // Grain records for the queue.
    logic [REC_W-1:0] rec_gap, rec_col;
    assign rec_gap = {!emit2, cnt_reg, sx_reg, sy_reg, sz_reg, at_reg, alo_reg, ahi_reg,
                      flo_reg, fhi_reg, zlo_reg, zhi_reg};
    assign rec_col = {1'b1, cnt_next, sx_next, sy_next, sz_next, at_next, alo_next,
                      ahi_next, flo_next, fhi_next, zlo_next, zhi_next};

    assign push0 = accept && (emit1 || emit2);
    assign push1 = accept && emit1 && emit2;
    assign rec0 = emit1 ? rec_gap : rec_col;
    assign rec1 = rec_col;

    // Open grain state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
            at_reg <= '0;
            alo_reg <= 16'hFFFF;
            ahi_reg <= '0;
            flo_reg <= '0;
            fhi_reg <= '0;
            zlo_reg <= '0;
            zhi_reg <= '0;
            prevz_reg <= '0;
        end
        else if (accept)
        begin
            prevz_reg <= z_pos;
            flo_reg <= flo_next;
            fhi_reg <= fhi_next;
            zlo_reg <= zlo_next;
            zhi_reg <= zhi_next;
            if (column_end)
            begin
                cnt_reg <= '0;
                sx_reg <= '0;
                sy_reg <= '0;
                sz_reg <= '0;
                at_reg <= '0;
                alo_reg <= 16'hFFFF;
                ahi_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sx_reg <= sx_next;
                sy_reg <= sy_next;
                sz_reg <= sz_next;
                at_reg <= at_next;
                alo_reg <= alo_next;
                ahi_reg <= ahi_next;
            end
        end
    end

endmodule

// File: rtl/core/vgg_queue.sv
// Four entry grain queue between front end and back end; takes up to two
// records a cycle and gives one. Depends on vgg_pkg.
module vgg_queue #(
    parameter int REC_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push0,
    input  logic               push1,
    input  logic [REC_W-1:0]   rec0,
    input  logic [REC_W-1:0]   rec1,
    input  logic               pop,
    output logic [REC_W-1:0]   head,
    output vgg_pkg::q_status_t status
);

    logic [REC_W-1:0] mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] fill_reg;
    logic [1:0] wp_plus;

    assign wp_plus = wp_reg + 2'd1;
    assign head = mem[rp_reg];
    assign status.room2 = (fill_reg <= 3'd2);
    assign status.nonempty = (fill_reg != 3'd0);

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push0)
            mem[wp_reg] <= rec0;
        if (push1)
            mem[wp_plus] <= rec1;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + {1'b0, push0} + {1'b0, push1};
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            fill_reg <= fill_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
        end
    end

endmodule

// File: rtl/core/vgg_back.sv
// Back end: takes grain records from the queue and works out the means
// and the volume with a serial multiplier and a serial divider. Depends on vgg_pkg.
module vgg_back #(
    parameter int MAX_CLUSTERS = vgg_pkg::MAX_CLUSTERS_DEF,
    parameter int CW = $clog2(MAX_CLUSTERS + 1),
    parameter int SW = 32 + CW,
    parameter int AW = 16 + CW,
    parameter int REC_W = 1 + CW + 3 * SW + AW + 32 + 20 + 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REC_W-1:0]    head,
    input  vgg_pkg::q_status_t  status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [9:0]          cluster_count,
    output logic signed [31:0]  mean_x,
    output logic signed [31:0]  mean_y,
    output logic signed [31:0]  mean_z,
    output logic signed [63:0]  volume,
    output logic [15:0]         area_least,
    output logic [15:0]         area_greatest,
    output logic signed [31:0]  z_at_frame_high,
    output logic signed [31:0]  z_at_frame_low,
    output logic [9:0]          frame_low,
    output logic [9:0]          frame_high,
    output logic                last_of_run
);

    localparam int DW = vgg_pkg::DIV_W;
    localparam int STW = $clog2(DW);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_DSET, S_DIV, S_OUT} state_t;

    state_t state_reg;
    logic [1:0] job_reg;

    // Captured record.
    logic [REC_W-1:0]     rec_reg;
    logic                 r_last;
    logic [CW-1:0]        r_cnt;
    logic signed [SW-1:0] r_sx, r_sy, r_sz;
    logic [AW-1:0]        r_at;
    logic [15:0]          r_alo, r_ahi;
    logic [9:0]           r_flo, r_fhi;
    logic signed [31:0]   r_zlo, r_zhi;

    assign {r_last, r_cnt, r_sx, r_sy, r_sz, r_at, r_alo, r_ahi,
            r_flo, r_fhi, r_zlo, r_zhi} = rec_reg;

    // Z length and its magnitude.
    logic signed [32:0] zlen;
    logic [32:0] zlen_abs;
    assign zlen = $signed({r_zlo[31], r_zlo}) - $signed({r_zhi[31], r_zhi});
    assign zlen_abs = zlen[32] ? -zlen : zlen;

    // Datapath registers.
    logic [DW-1:0] acc_reg, mcand_reg, dvd_reg;
    logic [vgg_pkg::ZMAG_W-1:0] mplier_reg;
    logic [CW-1:0] dsr_reg, rem_reg;
    logic neg_reg;
    logic [STW-1:0] step_reg;
    logic [31:0] mx_reg, my_reg, mz_reg;
    logic [63:0] vol_reg;

    // Divider operand selection for the current job.
    logic signed [SW-1:0] op_sum;
    logic [SW-1:0] op_abs;
    logic [DW-1:0] op_dvd;
    logic [CW-1:0] op_dsr;
    logic op_neg;

    always_comb
    begin
        case (job_reg)
            2'd0: op_sum = r_sx;
            2'd1: op_sum = r_sy;
            default: op_sum = r_sz;
        endcase
        op_abs = op_sum[SW-1] ? -op_sum : op_sum;
        if (job_reg == 2'd3)
        begin
            op_dvd = acc_reg;
            op_dsr = r_cnt - 1'b1;
            op_neg = zlen[32];
        end
        else
        begin
            op_dvd = {{(DW - SW){1'b0}}, op_abs};
            op_dsr = r_cnt;
            op_neg = op_sum[SW-1];
        end
    end

    // One restoring division step.
    logic [CW:0] rem_sh;
    logic q_bit;
    logic [DW-1:0] dvd_step, quot_signed, vol_sat;
    assign rem_sh = {rem_reg, dvd_reg[DW-1]};
    assign q_bit = (rem_sh >= {1'b0, dsr_reg});
    assign dvd_step = {dvd_reg[DW-2:0], q_bit};
    assign quot_signed = neg_reg ? -dvd_step : dvd_step;
    assign vol_sat = dvd_step[DW-1] ? vgg_pkg::VOLUME_SAT : dvd_step;

    logic vol_invalid;
    assign vol_invalid = (zlen == '0) || (r_cnt <= CW'(1));

    assign pop = (state_reg == S_IDLE) && status.nonempty;

    // Multiplier and divider datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (status.nonempty)
                    rec_reg <= head;
            end
            S_LOAD:
            begin
                acc_reg <= '0;
                mcand_reg <= {{(DW - AW){1'b0}}, r_at};
                mplier_reg <= zlen_abs[vgg_pkg::ZMAG_W-1:0];
                step_reg <= STW'(vgg_pkg::ZMAG_W - 1);
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg <= {mcand_reg[DW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[vgg_pkg::ZMAG_W-1:1]};
                step_reg <= step_reg - 1'b1;
            end
            S_DSET:
            begin
                dvd_reg <= op_dvd;
                dsr_reg <= op_dsr;
                neg_reg <= op_neg;
                rem_reg <= '0;
                step_reg <= STW'(DW - 1);
            end
            S_DIV:
            begin
                dvd_reg <= dvd_step;
                rem_reg <= q_bit ? CW'(rem_sh - {1'b0, dsr_reg}) : rem_sh[CW-1:0];
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    case (job_reg)
                        2'd0: mx_reg <= quot_signed[31:0];
                        2'd1: my_reg <= quot_signed[31:0];
                        2'd2: mz_reg <= quot_signed[31:0];
                        default: vol_reg <= neg_reg ? -vol_sat : vol_sat;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= '0;
            out_valid <= 1'b0;
            cluster_count <= '0;
            mean_x <= '0;
            mean_y <= '0;
            mean_z <= '0;
            volume <= '0;
            area_least <= '0;
            area_greatest <= '0;
            z_at_frame_high <= '0;
            z_at_frame_low <= '0;
            frame_low <= '0;
            frame_high <= '0;
            last_of_run <= 1'b0;
        end
        else
        begin
            // A taken result leaves unless a new one is loaded below.
            if (!out_stall && (state_reg != S_OUT))
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (status.nonempty)
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_MUL;
                    job_reg <= '0;
                end
                S_MUL:
                begin
                    if (step_reg == '0)
                        state_reg <= S_DSET;
                end
                S_DSET:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        job_reg <= job_reg + 2'd1;
                        state_reg <= (job_reg == 2'd3) ? S_OUT : S_DSET;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid <= 1'b1;
                        cluster_count <= 10'(r_cnt);
                        mean_x <= mx_reg;
                        mean_y <= my_reg;
                        mean_z <= mz_reg;
                        volume <= vol_invalid ? vgg_pkg::VOLUME_INVALID : vol_reg;
                        area_least <= r_alo;
                        area_greatest <= r_ahi;
                        z_at_frame_high <= r_zhi;
                        z_at_frame_low <= r_zlo;
                        frame_low <= r_flo;
                        frame_high <= r_fhi;
                        last_of_run <= r_last;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
